>>> rtl/pcl_pkg.sv
// Shared types and constants for the positional character list.
package pcl_pkg;

  localparam int CAPACITY = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = 6;
  localparam int CHAR_W   = 8;
  localparam int LEN_W    = 6;
  // signed scratch width for rank arithmetic: holds -1 .. 63 and 0 .. CAPACITY
  localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  localparam logic [2:0] OP_ADD    = 3'd0;
  localparam logic [2:0] OP_DELETE = 3'd1;
  localparam logic [2:0] OP_GET    = 3'd2;
  localparam logic [2:0] OP_SET    = 3'd3;
  localparam logic [2:0] OP_PRINT  = 3'd4;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_BADPOS = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;

  typedef struct packed {
    logic [2:0]        opcode;
    logic [POS_W-1:0]  position;
    logic [CHAR_W-1:0] char_in;
  } cmd_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [CHAR_W-1:0] char_out;
    logic              char_valid;
    logic              last;
    logic [LEN_W-1:0]  length;
  } res_t;

  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [CHAR_W-1:0] wdata;
    logic [IDX_W-1:0]  raddr;
  } mem_req_t;

endpackage

>>> rtl/positional_char_list_unit.sv
// Top level of the positional character list with registered result beat.
//
//  channel   signals                    direction  handshake
//  command   start, busy, cmd           in         taken when start && !busy
//  result    valid, result              out        one beat per cycle with valid high
//
//  Each entry moved by an add or delete costs a read state and a write state of the
//  store; a non-empty print reads and emits its entries one at a time, one beat per entry.
//  Results leave in the cycle after they are formed; the receiver cannot stall them.
//  Reset clears the count and sequencer; stored characters are not cleared.
module positional_char_list_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  pcl_pkg::cmd_t cmd,
  output logic          busy,
  output logic          valid,
  output pcl_pkg::res_t result
);

  pcl_pkg::mem_req_t          mreq;
  logic [pcl_pkg::CHAR_W-1:0] rdata;
  logic                       emit;
  pcl_pkg::res_t              res;

  pcl_mem u_mem (
    .clk   (clk),
    .req   (mreq),
    .rdata (rdata)
  );

  pcl_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .cmd   (cmd),
    .busy  (busy),
    .mreq  (mreq),
    .rdata (rdata),
    .emit  (emit),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      result <= res;
    end
  end

endmodule

>>> rtl/pcl_mem.sv
// Character store: one write port, one registered read port.
module pcl_mem (
  input  logic                      clk,
  input  pcl_pkg::mem_req_t         req,
  output logic [pcl_pkg::CHAR_W-1:0] rdata
);

  logic [pcl_pkg::CHAR_W-1:0] mem [pcl_pkg::CAPACITY];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[req.raddr];
  end

endmodule

>>> rtl/pcl_alu.sv
// Shared rank adder/subtractor used by the sequencer for all index math.
module pcl_alu (
  input  logic [pcl_pkg::CMP_W-1:0] a,
  input  logic [pcl_pkg::CMP_W-1:0] b,
  input  logic                      sub,
  output logic [pcl_pkg::CMP_W-1:0] sum
);

  always_comb begin
    if (sub) begin
      sum = a - b;
    end else begin
      sum = a + b;
    end
  end

endmodule

>>> rtl/pcl_ctrl.sv
// Sequencer: range checks, element moves, reads and result generation.
module pcl_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  pcl_pkg::cmd_t              cmd,
  output logic                       busy,
  output pcl_pkg::mem_req_t          mreq,
  input  logic [pcl_pkg::CHAR_W-1:0] rdata,
  output logic                       emit,
  output pcl_pkg::res_t              res
);

  typedef enum logic [14:0] {
    S_IDLE    = 15'h0001,
    S_CHK     = 15'h0002,
    S_CMP     = 15'h0004,
    S_INS_RD  = 15'h0008,
    S_INS_WR  = 15'h0010,
    S_FILL    = 15'h0020,
    S_DEL_RD  = 15'h0040,
    S_DEL_WR  = 15'h0080,
    S_DEL_END = 15'h0100,
    S_SET     = 15'h0200,
    S_GET_RD  = 15'h0400,
    S_GET_OUT = 15'h0800,
    S_PR_RD   = 15'h1000,
    S_PR_OUT  = 15'h2000,
    S_DONE    = 15'h4000
  } state_t;

  localparam int CW = pcl_pkg::CMP_W;
  localparam int IW = pcl_pkg::IDX_W;

  state_t                       state, state_next;
  logic [2:0]                   op;
  logic [pcl_pkg::CHAR_W-1:0]   ch;
  logic [CW-1:0]                tgt, tgt_next;
  logic [CW-1:0]                idx, idx_next;
  logic [IW-1:0]                wr_addr, wr_addr_next;
  logic [pcl_pkg::CNT_W-1:0]    count, count_next;
  logic [1:0]                   status, status_next;
  logic                         pos_zero, pos_zero_next;
  logic                         pr_last, pr_last_next;

  logic [CW-1:0] alu_a, alu_b, alu_sum;
  logic          alu_sub;
  logic [CW-1:0] n_ext;
  logic          diff_neg, diff_zero, bad;

  pcl_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .sub (alu_sub),
    .sum (alu_sum)
  );

  assign n_ext     = CW'(count);
  assign diff_neg  = alu_sum[CW-1];
  assign diff_zero = (alu_sum == '0);
  assign busy      = (state != S_IDLE);

  // in S_CMP the unit gives (position-1) - count
  always_comb begin
    if (op == pcl_pkg::OP_ADD) begin
      bad = pos_zero || (!diff_neg && !diff_zero);
    end else begin
      bad = pos_zero || !diff_neg;
    end
  end

  always_comb begin
    state_next    = state;
    tgt_next      = tgt;
    idx_next      = idx;
    wr_addr_next  = wr_addr;
    count_next    = count;
    status_next   = status;
    pos_zero_next = pos_zero;
    pr_last_next  = pr_last;
    alu_a         = idx;
    alu_b         = CW'(1);
    alu_sub       = 1'b0;
    mreq.we       = 1'b0;
    mreq.waddr    = wr_addr;
    mreq.wdata    = rdata;
    mreq.raddr    = tgt[IW-1:0];
    emit          = 1'b0;
    res.status     = status;
    res.char_out   = '0;
    res.char_valid = 1'b0;
    res.last       = 1'b1;
    res.length     = n_ext[pcl_pkg::LEN_W-1:0];

    unique case (state)
      S_IDLE: begin
        if (start) begin
          tgt_next   = CW'(cmd.position);
          state_next = S_CHK;
        end
      end
      S_CHK: begin
        alu_a         = tgt;
        alu_sub       = 1'b1;
        tgt_next      = alu_sum;
        pos_zero_next = alu_sum[CW-1];
        idx_next      = '0;
        if (op == pcl_pkg::OP_PRINT) begin
          status_next = pcl_pkg::ST_OK;
          state_next  = (count == '0) ? S_DONE : S_PR_RD;
        end else if (op > pcl_pkg::OP_PRINT) begin
          status_next = pcl_pkg::ST_BADPOS;
          state_next  = S_DONE;
        end else begin
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        alu_a       = tgt;
        alu_b       = n_ext;
        alu_sub     = 1'b1;
        status_next = pcl_pkg::ST_OK;
        if (bad) begin
          status_next = pcl_pkg::ST_BADPOS;
          state_next  = S_DONE;
        end else begin
          case (op)
            pcl_pkg::OP_ADD: begin
              if (count == pcl_pkg::CNT_W'(pcl_pkg::CAPACITY)) begin
                status_next = pcl_pkg::ST_FULL;
                state_next  = S_DONE;
              end else begin
                idx_next   = n_ext;
                state_next = S_INS_RD;
              end
            end
            pcl_pkg::OP_DELETE: begin
              idx_next   = tgt;
              state_next = S_DEL_RD;
            end
            pcl_pkg::OP_GET: state_next = S_GET_RD;
            default:         state_next = S_SET;
          endcase
        end
      end
      // insert: walk down from the tail, moving each entry up by one
      S_INS_RD: begin
        alu_sub = 1'b1;
        if (idx == tgt) begin
          state_next = S_FILL;
        end else begin
          mreq.raddr   = alu_sum[IW-1:0];
          wr_addr_next = idx[IW-1:0];
          idx_next     = alu_sum;
          state_next   = S_INS_WR;
        end
      end
      S_INS_WR: begin
        mreq.we    = 1'b1;
        state_next = S_INS_RD;
      end
      S_FILL: begin
        alu_a      = n_ext;
        mreq.we    = 1'b1;
        mreq.waddr = tgt[IW-1:0];
        mreq.wdata = ch;
        count_next = alu_sum[pcl_pkg::CNT_W-1:0];
        state_next = S_DONE;
      end
      // delete: walk up from the hole, moving each entry down by one
      S_DEL_RD: begin
        mreq.raddr = alu_sum[IW-1:0];
        if (alu_sum == n_ext) begin
          state_next = S_DEL_END;
        end else begin
          wr_addr_next = idx[IW-1:0];
          idx_next     = alu_sum;
          state_next   = S_DEL_WR;
        end
      end
      S_DEL_WR: begin
        mreq.we    = 1'b1;
        state_next = S_DEL_RD;
      end
      S_DEL_END: begin
        alu_a      = n_ext;
        alu_sub    = 1'b1;
        count_next = alu_sum[pcl_pkg::CNT_W-1:0];
        state_next = S_DONE;
      end
      S_SET: begin
        mreq.we    = 1'b1;
        mreq.waddr = tgt[IW-1:0];
        mreq.wdata = ch;
        state_next = S_DONE;
      end
      S_GET_RD: begin
        state_next = S_GET_OUT;
      end
      S_GET_OUT: begin
        emit           = 1'b1;
        res.status     = pcl_pkg::ST_OK;
        res.char_out   = rdata;
        res.char_valid = 1'b1;
        state_next     = S_IDLE;
      end
      S_PR_RD: begin
        mreq.raddr   = idx[IW-1:0];
        idx_next     = alu_sum;
        pr_last_next = (alu_sum == n_ext);
        state_next   = S_PR_OUT;
      end
      S_PR_OUT: begin
        emit           = 1'b1;
        res.status     = pcl_pkg::ST_OK;
        res.char_out   = rdata;
        res.char_valid = 1'b1;
        res.last       = pr_last;
        state_next     = pr_last ? S_IDLE : S_PR_RD;
      end
      S_DONE: begin
        emit       = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      op <= cmd.opcode;
      ch <= cmd.char_in;
    end
    tgt      <= tgt_next;
    idx      <= idx_next;
    wr_addr  <= wr_addr_next;
    status   <= status_next;
    pos_zero <= pos_zero_next;
    pr_last  <= pr_last_next;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= pcl_pkg::CNT_W'(pcl_pkg::CAPACITY))
    else $error("element count above capacity");

  a_ins_pair: assert property (@(posedge clk) disable iff (rst)
    (state == S_INS_WR) |-> ($past(state) == S_INS_RD))
    else $error("insert move write without preceding read");

  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    (state != S_FILL && state != S_DEL_END) |=> $stable(count))
    else $error("count changed outside add or delete");

  a_emit_state: assert property (@(posedge clk) disable iff (rst)
    emit |-> (state == S_GET_OUT || state == S_PR_OUT || state == S_DONE))
    else $error("result beat from a non-result state");

endmodule

>>> tb/sv/tb_positional_char_list_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for the positional character list unit.
module tb_positional_char_list_unit;
  import pcl_pkg::*;

  localparam logic [2:0] OP_UNDEF_FIRST = 3'd5;
  localparam logic [2:0] OP_UNDEF_LAST  = 3'd7;
  localparam int MAX_POS    = (1 << POS_W) - 1;
  localparam int CMD_W      = $bits(cmd_t);
  localparam int MAX_PRINTS = 50;

  logic clk   = 1'b0;
  logic rst   = 1'b1;
  logic start = 1'b0;
  cmd_t cmd   = '0;
  logic busy;
  logic valid;
  res_t result;

  positional_char_list_unit DUT (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .cmd   (cmd),
    .busy  (busy),
    .valid (valid),
    .result(result)
  );

  always #2 clk = ~clk;

  // shadow copy of the list
  logic [CHAR_W-1:0] list_chars [CAPACITY];
  int   list_len = 0;
  res_t pending_results [$];

  int err_count   = 0;
  int beats_seen  = 0;
  int cmds_sent   = 0;
  int prints_sent = 0;
  int full_hits   = 0;
  int bad_hits    = 0;
  int burst_left  = 0;

  function automatic cmd_t make_cmd(logic [2:0] op, int pos, int ch);
    cmd_t c;
    c.opcode   = op;
    c.position = POS_W'(pos);
    c.char_in  = CHAR_W'(ch);
    return c;
  endfunction

  function automatic void push_result(logic [1:0] st, logic [CHAR_W-1:0] ch, logic vld,
                                      logic lst);
    res_t r;
    r.status     = st;
    r.char_out   = ch;
    r.char_valid = vld;
    r.last       = lst;
    r.length     = LEN_W'(list_len);
    if (st == ST_BADPOS) bad_hits++;
    if (st == ST_FULL) full_hits++;
    pending_results.push_back(r);
  endfunction

  // Apply one accepted command to the shadow list and queue its result beats.
  function automatic void predict_list_results(cmd_t c);
    int p;
    int i;
    p = int'(c.position);
    case (c.opcode)
      OP_ADD: begin
        if (p < 1 || p > list_len + 1) begin
          push_result(ST_BADPOS, '0, 1'b0, 1'b1);
        end else if (list_len >= CAPACITY) begin
          push_result(ST_FULL, '0, 1'b0, 1'b1);
        end else begin
          for (i = list_len; i > p - 1; i--) list_chars[i] = list_chars[i-1];
          list_chars[p-1] = c.char_in;
          list_len++;
          push_result(ST_OK, '0, 1'b0, 1'b1);
        end
      end
      OP_DELETE: begin
        if (p < 1 || p > list_len) begin
          push_result(ST_BADPOS, '0, 1'b0, 1'b1);
        end else begin
          for (i = p - 1; i + 1 < list_len; i++) list_chars[i] = list_chars[i+1];
          list_len--;
          push_result(ST_OK, '0, 1'b0, 1'b1);
        end
      end
      OP_GET: begin
        if (p < 1 || p > list_len) push_result(ST_BADPOS, '0, 1'b0, 1'b1);
        else push_result(ST_OK, list_chars[p-1], 1'b1, 1'b1);
      end
      OP_SET: begin
        if (p < 1 || p > list_len) begin
          push_result(ST_BADPOS, '0, 1'b0, 1'b1);
        end else begin
          list_chars[p-1] = c.char_in;
          push_result(ST_OK, '0, 1'b0, 1'b1);
        end
      end
      OP_PRINT: begin
        prints_sent++;
        if (list_len == 0) begin
          push_result(ST_OK, '0, 1'b0, 1'b1);
        end else begin
          for (i = 0; i < list_len; i++)
            push_result(ST_OK, list_chars[i], 1'b1, i == list_len - 1);
        end
      end
      default: push_result(ST_BADPOS, '0, 1'b0, 1'b1);
    endcase
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    if (err_count < MAX_PRINTS)
      $display("%0t ns: mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    err_count++;
  endtask

  // result beat checker
  always @(posedge clk) begin
    res_t want;
    if (!rst && valid) begin
      beats_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("beat with nothing pending", int'(result), 0);
      end else begin
        want = pending_results.pop_front();
        if (result.status !== want.status)
          report_mismatch("status", int'(result.status), int'(want.status));
        if (result.char_out !== want.char_out)
          report_mismatch("char_out", int'(result.char_out), int'(want.char_out));
        if (result.char_valid !== want.char_valid)
          report_mismatch("char_valid", int'(result.char_valid), int'(want.char_valid));
        if (result.last !== want.last)
          report_mismatch("last", int'(result.last), int'(want.last));
        if (result.length !== want.length)
          report_mismatch("length", int'(result.length), int'(want.length));
      end
    end
  end

  // Drop start and put junk on the command bus during an idle gap; n of zero gives no gap.
  task automatic idle_gap(int n);
    if (n > 0) begin
      start <= 1'b0;
      cmd   <= cmd_t'(CMD_W'($urandom));
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_cmd(cmd_t c);
    if (burst_left == 0) begin
      idle_gap($urandom_range(0, 12));
      burst_left = $urandom_range(1, 10);
    end
    burst_left--;
    start <= 1'b1;
    cmd   <= c;
    do @(posedge clk); while (busy !== 1'b0);
    predict_list_results(c);
    cmds_sent++;
  endtask

  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic test_directed();
    send_cmd(make_cmd(OP_PRINT, 0, 0));          // empty list print
    send_cmd(make_cmd(OP_GET, 1, 0));            // get on empty list
    send_cmd(make_cmd(OP_DELETE, 0, 0));
    send_cmd(make_cmd(OP_SET, 1, 8'h11));
    send_cmd(make_cmd(OP_ADD, 2, 8'h22));        // past the end
    send_cmd(make_cmd(OP_ADD, 0, 8'h33));
    send_cmd(make_cmd(OP_ADD, 1, 8'h00));
    send_cmd(make_cmd(OP_ADD, 2, 8'hFF));        // append
    send_cmd(make_cmd(OP_ADD, 1, 8'hA5));        // insert at head
    send_cmd(make_cmd(OP_ADD, 3, 8'h5A));        // insert in the middle
    send_cmd(make_cmd(OP_GET, 1, 0));
    send_cmd(make_cmd(OP_GET, 4, 0));
    send_cmd(make_cmd(OP_GET, 5, 0));            // one past the end
    send_cmd(make_cmd(OP_GET, MAX_POS, 8'hFF));
    send_cmd(make_cmd(OP_SET, 4, 8'hC3));
    send_cmd(make_cmd(OP_SET, 5, 8'h3C));
    send_cmd(make_cmd(OP_PRINT, MAX_POS, 8'hFF));
    send_cmd(make_cmd(OP_DELETE, 2, 0));
    send_cmd(make_cmd(OP_DELETE, MAX_POS, 0));
    send_cmd(make_cmd(OP_DELETE, 3, 0));         // last entry
    send_cmd(make_cmd(OP_UNDEF_FIRST, 1, 8'h77));
    send_cmd(make_cmd(OP_UNDEF_FIRST + 3'd1, MAX_POS, 8'hFF));
    send_cmd(make_cmd(OP_UNDEF_LAST, 0, 0));
    send_cmd(make_cmd(OP_ADD, MAX_POS, 8'h44));
    send_cmd(make_cmd(OP_PRINT, 0, 0));
  endtask

  // Fill the list, poke it while full, then empty it again.
  task automatic test_capacity();
    while (list_len < CAPACITY)
      send_cmd(make_cmd(OP_ADD, $urandom_range(1, list_len + 1), $urandom_range(0, 255)));
    send_cmd(make_cmd(OP_ADD, list_len + 1, $urandom_range(0, 255)));
    send_cmd(make_cmd(OP_ADD, 1, $urandom_range(0, 255)));
    send_cmd(make_cmd(OP_ADD, list_len + 2, $urandom_range(0, 255)));  // bad wins over full
    send_cmd(make_cmd(OP_ADD, MAX_POS, 8'hFF));
    send_cmd(make_cmd(OP_PRINT, 0, 0));
    send_cmd(make_cmd(OP_GET, CAPACITY, 0));
    repeat (4) send_cmd(make_cmd(OP_SET, $urandom_range(1, list_len), $urandom_range(0, 255)));
    while (list_len > 0) begin
      if ($urandom_range(0, 3) == 0) send_cmd(make_cmd(OP_DELETE, list_len, 0));
      else send_cmd(make_cmd(OP_DELETE, $urandom_range(1, list_len), $urandom_range(0, 255)));
    end
    send_cmd(make_cmd(OP_PRINT, 0, 0));
  endtask

  task automatic test_random_ops(int n);
    int k;
    int r;
    int pos;
    logic [2:0] op;
    for (k = 0; k < n; k++) begin
      if (k == n / 2) drain_results();
      r = $urandom_range(0, 99);
      if (r < 4) op = 3'($urandom_range(OP_UNDEF_FIRST, OP_UNDEF_LAST));
      else if (r < 12) op = OP_PRINT;
      else if (r < 45) op = OP_ADD;
      else if (r < 65) op = OP_DELETE;
      else if (r < 82) op = OP_GET;
      else op = OP_SET;
      // mostly in-range positions, some anywhere in the field
      if ($urandom_range(0, 4) == 0) pos = $urandom_range(0, MAX_POS);
      else if (op == OP_ADD) pos = $urandom_range(1, list_len + 1);
      else if (list_len > 0) pos = $urandom_range(1, list_len);
      else pos = $urandom_range(0, 1);
      send_cmd(make_cmd(op, pos, $urandom_range(0, 255)));
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    drain_results();
    test_capacity();
    test_random_ops(130);
    drain_results();
    repeat (16) @(posedge clk);
    $display("Ran %0d commands (%0d prints), checked %0d result beats.",
             cmds_sent, prints_sent, beats_seen);
    $display("Saw %0d bad-position and %0d list-full answers, list filled to %0d entries.",
             bad_hits, full_hits, CAPACITY);
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

>>> files.f
rtl/pcl_pkg.sv
rtl/pcl_mem.sv
rtl/pcl_alu.sv
rtl/pcl_ctrl.sv
rtl/positional_char_list_unit.sv
tb/sv/tb_positional_char_list_unit.sv
